// ===== rtl/bld_pkg.sv =====
// ----------------------------------------------------------------------------
// bld_pkg
// Shared types and constants for the bounded linear deque.
// ----------------------------------------------------------------------------
`default_nettype none

package bld_pkg;

    localparam int DEPTH_DEFAULT = 32;

    typedef enum logic [1:0] {
        OP_INS_REAR  = 2'd0,
        OP_INS_FRONT = 2'd1,
        OP_DEL_REAR  = 2'd2,
        OP_DEL_FRONT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NO_REAR   = 2'd1,
        STS_NO_FRONT  = 2'd2,
        STS_UNDERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        op_t        mode;
        logic [7:0] value;
    } in_t;

    typedef struct packed {
        logic [7:0] data;
        status_t    status;
    } out_t;

    // Pointer conditions seen by the control logic
    typedef struct packed {
        logic rear_full;
        logic front_blocked;
        logic empty;
    } ptr_flags_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/bld_ram.sv =====
// ----------------------------------------------------------------------------
// bld_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/bld_ptr.sv =====
// ----------------------------------------------------------------------------
// bld_ptr
// Head and tail pointers: condition flags, store address, pointer update.
// ----------------------------------------------------------------------------
`default_nettype none

module bld_ptr #(
    parameter int DEPTH = bld_pkg::DEPTH_DEFAULT
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     upd,
    input  wire bld_pkg::op_t             mode,
    output bld_pkg::ptr_flags_t           flags,
    output logic [$clog2(DEPTH)-1:0]      addr
);

    // head spans 0..DEPTH, tail spans -1..DEPTH-1: one signed width covers both
    localparam int PTR_W  = $clog2(DEPTH + 1) + 1;
    localparam int ADDR_W = $clog2(DEPTH);

    logic signed [PTR_W-1:0] head_reg, head_next;
    logic signed [PTR_W-1:0] tail_reg, tail_next;
    logic signed [PTR_W-1:0] ptr_sel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '1;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    always_comb begin
        flags.rear_full     = (tail_reg == PTR_W'(DEPTH - 1));
        flags.front_blocked = (head_reg == '0);
        flags.empty         = (head_reg > tail_reg);
    end

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        case (mode)
            bld_pkg::OP_INS_REAR: begin
                ptr_sel   = tail_reg + PTR_W'(1);
                tail_next = upd ? ptr_sel : tail_reg;
            end
            bld_pkg::OP_INS_FRONT: begin
                ptr_sel   = head_reg - PTR_W'(1);
                head_next = upd ? ptr_sel : head_reg;
            end
            bld_pkg::OP_DEL_REAR: begin
                ptr_sel   = tail_reg;
                tail_next = upd ? (tail_reg - PTR_W'(1)) : tail_reg;
            end
            default: begin
                ptr_sel   = head_reg;
                head_next = upd ? (head_reg + PTR_W'(1)) : head_reg;
            end
        endcase
    end

    assign addr = ptr_sel[ADDR_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/bounded_linear_deque.sv =====
// ----------------------------------------------------------------------------
// bounded_linear_deque
// Double-ended byte queue over a linear store that never wraps.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_payload carry one request transaction: an op code
//   (insert rear, insert front, delete rear, delete front) and a byte.
//   m_valid/m_ready/m_payload return exactly one result transaction per
//   request: the byte removed by a successful delete (zero otherwise) and a
//   status (ok, no room at rear, no room at front, underflow).
//   Inserts and failed requests are decided in the accept cycle, and the
//   result is in the output register from the next cycle. A successful
//   delete reads the store RAM, whose read is registered, so its result
//   passes through the RAM read register and then the output register.
//   Throughput: one insert or failed request per cycle while the output is
//   drained; a successful delete blocks new requests until its read returns.
//   s_ready is high while no delete read is pending and the output register
//   is empty or being drained in the same cycle.
//   Reset (aresetn low, synchronous) empties the queue: head at slot zero,
//   tail at minus one, no result pending. The store is not cleared; only
//   written slots are ever read.
//   When the receiver stalls, the result holds in the output register and
//   s_ready drops until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_linear_deque #(
    parameter int DEPTH = bld_pkg::DEPTH_DEFAULT
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire bld_pkg::in_t  s_payload,
    output logic               m_valid,
    input  wire logic          m_ready,
    output bld_pkg::out_t      m_payload
);

    localparam int ADDR_W = $clog2(DEPTH);

    bld_pkg::state_t     state_reg, state_next;
    logic                m_valid_reg, m_valid_next;
    bld_pkg::out_t       out_reg, out_next;

    bld_pkg::ptr_flags_t flags;
    logic [ADDR_W-1:0]   mem_addr;
    logic [7:0]          rd_data;
    logic                accept;
    logic                op_ok;
    logic                wr_en;
    bld_pkg::status_t    fail_status;

    assign s_ready = (state_reg == bld_pkg::ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    // Check the request against the pointer conditions
    always_comb begin
        case (s_payload.mode)
            bld_pkg::OP_INS_REAR: begin
                op_ok       = !flags.rear_full;
                fail_status = bld_pkg::STS_NO_REAR;
            end
            bld_pkg::OP_INS_FRONT: begin
                op_ok       = !flags.front_blocked;
                fail_status = bld_pkg::STS_NO_FRONT;
            end
            default: begin
                op_ok       = !flags.empty;
                fail_status = bld_pkg::STS_UNDERFLOW;
            end
        endcase
    end

    assign wr_en = accept && op_ok &&
                   ((s_payload.mode == bld_pkg::OP_INS_REAR) ||
                    (s_payload.mode == bld_pkg::OP_INS_FRONT));

    bld_ptr #(
        .DEPTH(DEPTH)
    ) u_ptr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (accept && op_ok),
        .mode    (s_payload.mode),
        .flags   (flags),
        .addr    (mem_addr)
    );

    bld_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (mem_addr),
        .wr_data (s_payload.value),
        .rd_addr (mem_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bld_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        out_next     = out_reg;
        case (state_reg)
            bld_pkg::ST_IDLE: begin
                if (accept) begin
                    if (op_ok && !wr_en) begin
                        // successful delete: wait for the RAM read
                        state_next = bld_pkg::ST_READ;
                    end else begin
                        m_valid_next    = 1'b1;
                        out_next.data   = '0;
                        out_next.status = op_ok ? bld_pkg::STS_OK : fail_status;
                    end
                end
            end
            bld_pkg::ST_READ: begin
                // output register was freed when the delete was accepted
                state_next      = bld_pkg::ST_IDLE;
                m_valid_next    = 1'b1;
                out_next.data   = rd_data;
                out_next.status = bld_pkg::STS_OK;
            end
            default: begin
                state_next = bld_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

endmodule

`default_nettype wire
